// File: src/btb_plru_pkg.sv
// Package for the bit-PLRU branch target buffer.
// Holds the command codes and the default sizes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package btb_plru_pkg;

    localparam int ENTRIES_DEF      = 4;
    localparam int ADDRESS_BITS_DEF = 32;
    localparam int COUNTER_BITS_DEF = 2;

    localparam int ACTION_BITS = 2;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_NONE   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_UPDATE = 2'd2
    } action_t;

endpackage

`default_nettype wire

// File: src/branch_target_buffer_bit_plru_top.sv
// Top level of the fully associative branch target buffer with bit-PLRU replacement.
// Uses btb_plru_pkg for command codes and default sizes.
//
// One beat is accepted whenever start is high; busy never rises, so a beat may be
// issued every cycle. The result of a beat appears on the result ports in the cycle
// after it is accepted, marked by done for exactly one cycle, and must be taken then:
// the receiver cannot stall. The lookup sees the table as it was before that beat's
// write or update command, so a lookup never sees the entry written in its own beat;
// the next beat sees the new entry. The result is held in a single result register
// after the parallel compare across all entries.
`timescale 1ns / 1ps
`default_nettype none

module branch_target_buffer_bit_plru_top #(
    parameter int ENTRIES      = btb_plru_pkg::ENTRIES_DEF,
    parameter int ADDRESS_BITS = btb_plru_pkg::ADDRESS_BITS_DEF,
    parameter int COUNTER_BITS = btb_plru_pkg::COUNTER_BITS_DEF,
    localparam int IDX_BITS    = (ENTRIES > 2) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [ADDRESS_BITS-1:0]             lookup_address,
    input  wire logic [btb_plru_pkg::ACTION_BITS-1:0] action,
    input  wire logic [IDX_BITS-1:0]                 entry_pointer,
    input  wire logic [ADDRESS_BITS-1:0]             branch_address,
    input  wire logic [ADDRESS_BITS-1:0]             target_address,
    input  wire logic [COUNTER_BITS-1:0]             counter_value,
    output logic                                     done,
    output logic                                     miss,
    output logic [ADDRESS_BITS-1:0]                  predicted_target,
    output logic                                     hit_priority,
    output logic [COUNTER_BITS-1:0]                  hit_counter,
    output logic [IDX_BITS-1:0]                      result_pointer
);

    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam logic [IDX_BITS:0]   ENTRIES_W  = (IDX_BITS+1)'(ENTRIES);
    localparam logic [CNT_BITS-1:0] CNT_LAST_0 = CNT_BITS'(ENTRIES - 1);
    localparam logic [CNT_BITS-1:0] CNT_ONE    = CNT_BITS'(1);

    logic [ENTRIES-1:0]      valid_reg, valid_next;
    logic [ADDRESS_BITS-1:0] branch_reg [ENTRIES];
    logic [ADDRESS_BITS-1:0] branch_next [ENTRIES];
    logic [ADDRESS_BITS-1:0] target_reg [ENTRIES];
    logic [ADDRESS_BITS-1:0] target_next [ENTRIES];
    logic [COUNTER_BITS-1:0] counter_reg [ENTRIES];
    logic [COUNTER_BITS-1:0] counter_next [ENTRIES];
    logic [ENTRIES-1:0]      prio_reg, prio_next;
    logic                    pol_reg, pol_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;

    logic                    done_reg;
    logic                    miss_reg, miss_next;
    logic [ADDRESS_BITS-1:0] tgt_reg, tgt_next;
    logic                    hprio_reg, hprio_next;
    logic [COUNTER_BITS-1:0] hcnt_reg, hcnt_next;
    logic [IDX_BITS-1:0]     rptr_reg, rptr_next;

    logic                    accept;
    logic                    hit;
    logic [IDX_BITS-1:0]     hit_idx;
    logic [IDX_BITS-1:0]     repl_idx;
    logic                    cmd_ok;
    logic                    last_low;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // lookup against the current table
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        repl_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i] && (branch_reg[i] == lookup_address))
            begin
                hit     = 1'b1;
                hit_idx = IDX_BITS'(i);
            end
            if (!valid_reg[i] || (prio_reg[i] == pol_reg))
            begin
                repl_idx = IDX_BITS'(i);
            end
        end

        if (hit)
        begin
            miss_next  = 1'b0;
            tgt_next   = target_reg[hit_idx];
            hprio_next = prio_reg[hit_idx];
            hcnt_next  = counter_reg[hit_idx];
            rptr_next  = hit_idx;
        end
        else
        begin
            miss_next  = 1'b1;
            tgt_next   = '0;
            hprio_next = 1'b0;
            hcnt_next  = '0;
            rptr_next  = repl_idx;
        end
    end

    // command and promotion
    always_comb
    begin
        valid_next   = valid_reg;
        branch_next  = branch_reg;
        target_next  = target_reg;
        counter_next = counter_reg;
        prio_next    = prio_reg;
        pol_next     = pol_reg;
        cnt_next     = cnt_reg;

        cmd_ok   = accept
                && (action inside {btb_plru_pkg::ACT_WRITE, btb_plru_pkg::ACT_UPDATE})
                && ({1'b0, entry_pointer} < ENTRIES_W);
        last_low = (!pol_reg && (cnt_reg == CNT_LAST_0))
                || (pol_reg && (cnt_reg == CNT_ONE));

        if (cmd_ok)
        begin
            valid_next[entry_pointer]   = 1'b1;
            counter_next[entry_pointer] = counter_value;
            if (action == btb_plru_pkg::ACT_WRITE)
            begin
                branch_next[entry_pointer] = branch_address;
                target_next[entry_pointer] = target_address;
            end
            if (prio_reg[entry_pointer] == pol_reg)
            begin
                if (last_low)
                begin
                    pol_next = !pol_reg;
                end
                else if (!prio_reg[entry_pointer])
                begin
                    prio_next[entry_pointer] = 1'b1;
                    cnt_next = cnt_reg + CNT_ONE;
                end
                else
                begin
                    prio_next[entry_pointer] = 1'b0;
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - CNT_ONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            prio_reg  <= '0;
            pol_reg   <= 1'b0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                branch_reg[i]  <= '0;
                target_reg[i]  <= '0;
                counter_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg   <= valid_next;
            branch_reg  <= branch_next;
            target_reg  <= target_next;
            counter_reg <= counter_next;
            prio_reg    <= prio_next;
            pol_reg     <= pol_next;
            cnt_reg     <= cnt_next;
            done_reg    <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            miss_reg  <= miss_next;
            tgt_reg   <= tgt_next;
            hprio_reg <= hprio_next;
            hcnt_reg  <= hcnt_next;
            rptr_reg  <= rptr_next;
        end
    end

    assign done             = done_reg;
    assign miss             = miss_reg;
    assign predicted_target = tgt_reg;
    assign hit_priority     = hprio_reg;
    assign hit_counter      = hcnt_reg;
    assign result_pointer   = rptr_reg;

    a_count_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == CNT_BITS'($countones(prio_reg)))
        else $error("priority bit count out of step");

    a_one_result_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted beat gave no result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without accepted beat");

    a_miss_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && miss) |-> ((predicted_target == '0) && !hit_priority
                            && (hit_counter == '0)))
        else $error("miss result carries hit data");

    a_pointer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, result_pointer} < ENTRIES_W))
        else $error("result pointer beyond table");

endmodule

`default_nettype wire

// File: test/tb_branch_target_buffer_bit_plru_top.sv
// Testbench for branch_target_buffer_bit_plru_top: directed and random lookup/command beats,
// every result checked against an in-bench model of the table and its bit-PLRU state.
// Depends on btb_plru_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb_branch_target_buffer_bit_plru_top;

    localparam int ENTRIES_N = btb_plru_pkg::ENTRIES_DEF;
    localparam int IDX_W = $clog2(btb_plru_pkg::ENTRIES_DEF);
    localparam int AW = btb_plru_pkg::ADDRESS_BITS_DEF;
    localparam int CW = btb_plru_pkg::COUNTER_BITS_DEF;
    localparam int AB = btb_plru_pkg::ACTION_BITS;
    localparam logic [AB-1:0] ACT_RESERVED = 2'd3;
    localparam int RANDOM_BEATS = 950;

    typedef struct {
        logic [AW-1:0]          lookup;
        logic [AB-1:0]          act;
        logic [IDX_W-1:0]       ptr;
        logic [AW-1:0]          branch;
        logic [AW-1:0]          target;
        logic [CW-1:0]          counter;
        int unsigned            idle_pct;
    } btb_beat_t;

    typedef struct {
        logic             miss;
        logic [AW-1:0]    target;
        logic             prio;
        logic [CW-1:0]    counter;
        logic [IDX_W-1:0] ptr;
    } btb_lookup_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [AW-1:0]          lookup_address = '0;
    logic [AB-1:0]          action = btb_plru_pkg::ACT_NONE;
    logic [IDX_W-1:0]       entry_pointer = '0;
    logic [AW-1:0]          branch_address = '0;
    logic [AW-1:0]          target_address = '0;
    logic [CW-1:0]          counter_value = '0;
    logic                   done;
    logic                   miss;
    logic [AW-1:0]          predicted_target;
    logic                   hit_priority;
    logic [CW-1:0]          hit_counter;
    logic [IDX_W-1:0]       result_pointer;

    btb_beat_t   beats_pending[$];
    btb_lookup_t expected_lookups[$];
    int unsigned error_count = 0;

    // model of the table
    logic          tbl_valid[ENTRIES_N];
    logic [AW-1:0] tbl_branch[ENTRIES_N];
    logic [AW-1:0] tbl_target[ENTRIES_N];
    logic [CW-1:0] tbl_counter[ENTRIES_N];
    logic          tbl_prio[ENTRIES_N];
    logic          low_polarity;
    int unsigned   prio_set_count;

    branch_target_buffer_bit_plru_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .lookup_address   (lookup_address),
        .action           (action),
        .entry_pointer    (entry_pointer),
        .branch_address   (branch_address),
        .target_address   (target_address),
        .counter_value    (counter_value),
        .done             (done),
        .miss             (miss),
        .predicted_target (predicted_target),
        .hit_priority     (hit_priority),
        .hit_counter      (hit_counter),
        .result_pointer   (result_pointer)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic add_beat(input logic [AW-1:0] lk, input logic [AB-1:0] act,
                            input int unsigned ptr, input logic [AW-1:0] br,
                            input logic [AW-1:0] tg, input int unsigned cv,
                            input int unsigned idle_pct);
        btb_beat_t b;
        b.lookup   = lk;
        b.act      = act;
        b.ptr      = IDX_W'(ptr);
        b.branch   = br;
        b.target   = tg;
        b.counter  = CW'(cv);
        b.idle_pct = idle_pct;
        beats_pending.push_back(b);
    endtask

    // lookup against the old table, then apply the command
    task automatic lookup_then_apply(input btb_beat_t b);
        btb_lookup_t r;
        logic [IDX_W-1:0] victim;
        int unsigned e;
        bit last;
        r = '{miss: 1'b1, target: '0, prio: 1'b0, counter: '0, ptr: '0};
        victim = '0;
        for (int i = 0; i < ENTRIES_N; i++)
        begin
            if (tbl_valid[i] && tbl_branch[i] == b.lookup)
            begin
                r.miss    = 1'b0;
                r.target  = tbl_target[i];
                r.prio    = tbl_prio[i];
                r.counter = tbl_counter[i];
                r.ptr     = IDX_W'(i);
            end
            if (!tbl_valid[i] || tbl_prio[i] == low_polarity)
                victim = IDX_W'(i);
        end
        if (r.miss)
            r.ptr = victim;
        expected_lookups.push_back(r);

        if ((b.act == btb_plru_pkg::ACT_WRITE || b.act == btb_plru_pkg::ACT_UPDATE)
            && b.ptr < ENTRIES_N)
        begin
            e = b.ptr;
            tbl_valid[e]   = 1'b1;
            tbl_counter[e] = b.counter;
            if (b.act == btb_plru_pkg::ACT_WRITE)
            begin
                tbl_branch[e] = b.branch;
                tbl_target[e] = b.target;
            end
            if (tbl_prio[e] == low_polarity)
            begin
                last = (low_polarity == 1'b0 && prio_set_count == ENTRIES_N - 1) ||
                       (low_polarity == 1'b1 && prio_set_count == 1);
                if (last)
                    low_polarity = ~low_polarity;
                else if (tbl_prio[e] == 1'b0)
                begin
                    tbl_prio[e] = 1'b1;
                    prio_set_count++;
                end
                else
                begin
                    tbl_prio[e] = 1'b0;
                    if (prio_set_count > 0)
                        prio_set_count--;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin : driver
        btb_beat_t beat;
        bit holding;
        if (rst_n)
        begin
            holding = start;
            if (start && !busy)
            begin
                beat = beats_pending.pop_front();
                lookup_then_apply(beat);
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (beats_pending.size() != 0 &&
                    $urandom_range(99) >= beats_pending[0].idle_pct)
                begin
                    beat = beats_pending[0];
                    lookup_address <= beat.lookup;
                    action         <= beat.act;
                    entry_pointer  <= beat.ptr;
                    branch_address <= beat.branch;
                    target_address <= beat.target;
                    counter_value  <= beat.counter;
                    start          <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        btb_lookup_t want;
        if (rst_n && done)
        begin
            if (expected_lookups.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: result beat with nothing pending: miss=%0b ptr=%0d",
                             $time, miss, result_pointer);
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (miss !== want.miss || predicted_target !== want.target ||
                    hit_priority !== want.prio || hit_counter !== want.counter ||
                    result_pointer !== want.ptr)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: mismatch exp miss=%0b tgt=%h prio=%0b cnt=%0d ",
                                 $time, want.miss, want.target, want.prio, want.counter,
                                 "ptr=%0d got miss=%0b tgt=%h prio=%0b cnt=%0d ptr=%0d",
                                 want.ptr, miss, predicted_target, hit_priority,
                                 hit_counter, result_pointer);
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [AW-1:0] pool[6];
        int unsigned idle_by_phase[4];
        int unsigned pct;
        int unsigned pick;
        logic [AB-1:0] act;
        logic [AW-1:0] lk;
        logic [AW-1:0] br;

        for (int i = 0; i < ENTRIES_N; i++)
        begin
            tbl_valid[i]   = 1'b0;
            tbl_branch[i]  = '0;
            tbl_target[i]  = '0;
            tbl_counter[i] = '0;
            tbl_prio[i]    = 1'b0;
        end
        low_polarity   = 1'b0;
        prio_set_count = 0;

        // directed: empty table, same-beat write, multiple matches, both polarity flips
        add_beat(32'h0, btb_plru_pkg::ACT_NONE, 0, 32'h0, 32'h0, 0, 0);
        add_beat(32'hFFFF_FFFF, btb_plru_pkg::ACT_WRITE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 3, 0);
        add_beat(32'hFFFF_FFFF, btb_plru_pkg::ACT_NONE, 0, 32'h0, 32'h0, 0, 0);
        add_beat(32'h0, btb_plru_pkg::ACT_WRITE, 3, 32'h0, 32'h0, 0, 0);
        add_beat(32'h0, btb_plru_pkg::ACT_UPDATE, 1, 32'h7FFF_FFFF, 32'hFFFF_0000, 2, 0);
        add_beat(32'h0, btb_plru_pkg::ACT_NONE, 2, 32'h0, 32'h0, 3, 0);
        add_beat(32'h8000_0000, btb_plru_pkg::ACT_WRITE, 2, 32'h8000_0000, 32'h1234_5678,
                 1, 0);
        add_beat(32'h8000_0000, btb_plru_pkg::ACT_NONE, 0, 32'h0, 32'h0, 0, 0);
        add_beat(32'h5555_5555, btb_plru_pkg::ACT_UPDATE, 0, 32'h0, 32'h0, 1, 0);
        add_beat(32'hAAAA_AAAA, btb_plru_pkg::ACT_UPDATE, 1, 32'h0, 32'h0, 0, 0);
        add_beat(32'h0, btb_plru_pkg::ACT_UPDATE, 3, 32'h0, 32'h0, 3, 0);
        add_beat(32'h0, btb_plru_pkg::ACT_UPDATE, 2, 32'h0, 32'h0, 2, 0);
        add_beat(32'h0, btb_plru_pkg::ACT_UPDATE, 3, 32'h0, 32'h0, 1, 0);
        add_beat(32'hDEAD_BEEF, ACT_RESERVED, 0, 32'hDEAD_BEEF, 32'hCAFE_F00D, 3, 0);
        add_beat(32'hDEAD_BEEF, btb_plru_pkg::ACT_NONE, 1, 32'h0, 32'h0, 0, 0);
        add_beat(32'hFFFF_FFFF, btb_plru_pkg::ACT_NONE, 0, 32'h0, 32'h0, 0, 0);
        add_beat(32'h8000_0000, ACT_RESERVED, 3, 32'h0, 32'h0, 0, 0);
        add_beat(32'h0, btb_plru_pkg::ACT_NONE, 0, 32'h0, 32'h0, 0, 0);

        // random: small address pool so lookups hit and entries collide
        pool[0] = 32'h0;
        pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 6; i++)
            pool[i] = $urandom;
        idle_by_phase = '{0, 68, 0, 13};
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            pct = idle_by_phase[(n * 4) / RANDOM_BEATS];
            if (n % 97 > 80)
                pct = 0;
            pick = $urandom_range(99);
            if (pick < 30)
                act = btb_plru_pkg::ACT_NONE;
            else if (pick < 65)
                act = btb_plru_pkg::ACT_WRITE;
            else if (pick < 90)
                act = btb_plru_pkg::ACT_UPDATE;
            else
                act = ACT_RESERVED;
            lk = ($urandom_range(99) < 75) ? pool[$urandom_range(5)] : $urandom;
            br = ($urandom_range(99) < 85) ? pool[$urandom_range(5)] : $urandom;
            add_beat(lk, act, $urandom_range(ENTRIES_N - 1), br, $urandom,
                     $urandom_range((1 << CW) - 1), pct);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_pending.size() != 0)
            @(posedge clk);
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        error_count += expected_lookups.size();
        if (error_count == 0)
            $display("tb_branch_target_buffer_bit_plru_top: clean");
        else
            $display("tb_branch_target_buffer_bit_plru_top: errors");
        $finish;
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("tb_branch_target_buffer_bit_plru_top: errors");
        $finish;
    end

endmodule

// File: branch_target_buffer_bit_plru_top.f
src/btb_plru_pkg.sv
src/branch_target_buffer_bit_plru_top.sv
test/tb_branch_target_buffer_bit_plru_top.sv
